// ===== rtl/hsvrgb_pkg.sv =====
// Package for the HSVA to RGBA converter: constants, sector codes and the
// payload structs passed between pipeline stages. No dependencies.
`default_nettype none

package hsvrgb_pkg;

  // Q1.15 unity and the hue span of one 60 degree sector (1/64 degree units)
  localparam logic [15:0] Q15_ONE          = 16'd32768;
  localparam int          HUE_SECTOR_UNITS = 3840;
  localparam int          SECTOR_COUNT     = 6;
  localparam int          HUE_W            = 15;
  localparam int          REM_W            = 12;
  // Largest whole-sector count a 15-bit hue can hold
  localparam int          QUOT_MAX         = (2**HUE_W - 1) / HUE_SECTOR_UNITS;

  // f = floor(rem * 128 / 15), done as a multiply by ceil(2^23 / 15)
  localparam int          FRAC_SHIFT       = 23;
  localparam logic [19:0] FRAC_RECIP       = 20'((2**FRAC_SHIFT + 14) / 15);

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [15:0]      saturation;
    logic [15:0]      brightness;
    logic [15:0]      alpha;
  } hsva_t;

  typedef struct packed {
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [15:0]      sat;
    logic [15:0]      val;
    logic [15:0]      alpha;
  } split_t;

  typedef struct packed {
    sector_t     sector;
    logic [15:0] frac;
    logic [15:0] sat;
    logic [15:0] val;
    logic [15:0] p;
    logic [15:0] alpha;
  } frac_t;

  typedef struct packed {
    sector_t     sector;
    logic [15:0] sf;
    logic [15:0] sg;
    logic [15:0] val;
    logic [15:0] p;
    logic [15:0] alpha;
  } scale_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } rgba_t;

endpackage

`default_nettype wire

// ===== rtl/hsvrgb_if.sv =====
// Valid/ready channel interfaces for the HSVA input and RGBA result.
// Depends on nothing.
`default_nettype none

interface hsvrgb_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;
  logic [15:0] alpha_in;

  modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
  modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

interface hsvrgb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsvrgb_split.sv =====
// Stage 1: splits hue into sector and remainder, clamps S and V to 1.0.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_split (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hsvrgb_pkg::hsva_t  up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hsvrgb_pkg::split_t      dn_data
);

  logic                          vld_r;
  hsvrgb_pkg::split_t            data_r;
  hsvrgb_pkg::split_t            data_nxt;
  logic [3:0]                    quot;
  logic [hsvrgb_pkg::HUE_W-1:0]  base;
  logic [hsvrgb_pkg::HUE_W-1:0]  rem_full;

  // Whole sectors by parallel compares against multiples of one sector
  always_comb begin
    quot = 4'd0;
    base = '0;
    for (int k = 1; k <= hsvrgb_pkg::QUOT_MAX; k++) begin
      if (up_data.hue >= hsvrgb_pkg::HUE_W'(hsvrgb_pkg::HUE_SECTOR_UNITS * k)) begin
        quot = 4'(k);
        base = hsvrgb_pkg::HUE_W'(hsvrgb_pkg::HUE_SECTOR_UNITS * k);
      end
    end
  end

  assign rem_full = up_data.hue - base;

  // Sector wraps modulo six; S and V saturate at 1.0
  always_comb begin
    data_nxt.sector = (quot >= 4'(hsvrgb_pkg::SECTOR_COUNT))
                    ? hsvrgb_pkg::sector_t'(3'(quot - 4'(hsvrgb_pkg::SECTOR_COUNT)))
                    : hsvrgb_pkg::sector_t'(quot[2:0]);
    data_nxt.rem    = rem_full[hsvrgb_pkg::REM_W-1:0];
    data_nxt.sat    = (up_data.saturation > hsvrgb_pkg::Q15_ONE) ? hsvrgb_pkg::Q15_ONE
                                                                 : up_data.saturation;
    data_nxt.val    = (up_data.brightness > hsvrgb_pkg::Q15_ONE) ? hsvrgb_pkg::Q15_ONE
                                                                 : up_data.brightness;
    data_nxt.alpha  = up_data.alpha;
  end

  // Pipeline register
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/hsvrgb_frac.sv =====
// Stage 2: sector fraction f by reciprocal multiply, and p = v(1-s).
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_frac (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire hsvrgb_pkg::split_t  up_data,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output hsvrgb_pkg::frac_t        dn_data
);

  logic               vld_r;
  hsvrgb_pkg::frac_t  data_r;
  hsvrgb_pkg::frac_t  data_nxt;
  logic [18:0]        rem_x128;
  logic [38:0]        frac_prod;
  logic [31:0]        p_prod;

  // f = floor(rem * 32768 / 3840) = floor(rem * 128 / 15)
  assign rem_x128  = {up_data.rem, 7'd0};
  assign frac_prod = 39'(rem_x128) * 39'(hsvrgb_pkg::FRAC_RECIP);
  assign p_prod    = 32'(up_data.val) * 32'(hsvrgb_pkg::Q15_ONE - up_data.sat);

  always_comb begin
    data_nxt.sector = up_data.sector;
    data_nxt.frac   = frac_prod[hsvrgb_pkg::FRAC_SHIFT +: 16];
    data_nxt.sat    = up_data.sat;
    data_nxt.val    = up_data.val;
    data_nxt.p      = p_prod[30:15];
    data_nxt.alpha  = up_data.alpha;
  end

  // Pipeline register
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/hsvrgb_scale.sv =====
// Stage 3: scaled saturations sf = s*f and sg = s*(1-f).
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_scale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hsvrgb_pkg::frac_t  up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hsvrgb_pkg::scale_t      dn_data
);

  logic                vld_r;
  hsvrgb_pkg::scale_t  data_r;
  hsvrgb_pkg::scale_t  data_nxt;
  logic [31:0]         sf_prod;
  logic [31:0]         sg_prod;

  assign sf_prod = 32'(up_data.sat) * 32'(up_data.frac);
  assign sg_prod = 32'(up_data.sat) * 32'(hsvrgb_pkg::Q15_ONE - up_data.frac);

  always_comb begin
    data_nxt.sector = up_data.sector;
    data_nxt.sf     = sf_prod[30:15];
    data_nxt.sg     = sg_prod[30:15];
    data_nxt.val    = up_data.val;
    data_nxt.p      = up_data.p;
    data_nxt.alpha  = up_data.alpha;
  end

  // Pipeline register
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/hsvrgb_route.sv =====
// Stage 4: q = v(1-sf), t = v(1-sg), then routes v, p, q, t by sector.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_route (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire hsvrgb_pkg::scale_t  up_data,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output hsvrgb_pkg::rgba_t        dn_data
);

  logic               vld_r;
  hsvrgb_pkg::rgba_t  data_r;
  hsvrgb_pkg::rgba_t  data_nxt;
  logic [31:0]        q_prod;
  logic [31:0]        t_prod;
  logic [15:0]        q;
  logic [15:0]        t;
  logic [15:0]        v;
  logic [15:0]        p;

  assign q_prod = 32'(up_data.val) * 32'(hsvrgb_pkg::Q15_ONE - up_data.sf);
  assign t_prod = 32'(up_data.val) * 32'(hsvrgb_pkg::Q15_ONE - up_data.sg);
  assign q      = q_prod[30:15];
  assign t      = t_prod[30:15];
  assign v      = up_data.val;
  assign p      = up_data.p;

  // Sector routing
  always_comb begin
    data_nxt.alpha = up_data.alpha;
    case (up_data.sector)
      hsvrgb_pkg::SEC_RED: begin
        data_nxt.red = v; data_nxt.green = t; data_nxt.blue = p;
      end
      hsvrgb_pkg::SEC_YELLOW: begin
        data_nxt.red = q; data_nxt.green = v; data_nxt.blue = p;
      end
      hsvrgb_pkg::SEC_GREEN: begin
        data_nxt.red = p; data_nxt.green = v; data_nxt.blue = t;
      end
      hsvrgb_pkg::SEC_CYAN: begin
        data_nxt.red = p; data_nxt.green = q; data_nxt.blue = v;
      end
      hsvrgb_pkg::SEC_BLUE: begin
        data_nxt.red = t; data_nxt.green = p; data_nxt.blue = v;
      end
      default: begin
        data_nxt.red = v; data_nxt.green = p; data_nxt.blue = q;
      end
    endcase
  end

  // Output register
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// HSVA to RGBA converter, top level. Depends on hsvrgb_pkg, the channel
// interfaces in hsvrgb_if.sv and the four stage modules.
//
// Usage:
//   in_pix  (sink)  : hue in 1/64 degree, saturation, brightness and alpha
//                     in Q1.15. A transfer happens when valid and ready are
//                     both high at a rising clock edge.
//   out_pix (source): red, green, blue and alpha in Q1.15, same handshake.
//   Hue of 360 degrees or more wraps by whole sectors; saturation and
//   brightness above 1.0 are clamped; alpha passes through untouched.
// Throughput: one pixel per clock when not stalled, set by the four
//   register stages (sector split, fraction multiply, saturation scaling,
//   final multiply and channel routing), each holding at most one
//   multiplier level; an input reaches out_pix through them in order.
// Reset: synchronous, active low; clears every stage valid bit, so the
//   pipeline comes up empty and ready.
// Stall: each stage holds its item while the next stage is full and not
//   ready; empty stages keep filling, so in_pix.ready stays high until all
//   four stages hold data and out_pix.ready is low.
`default_nettype none

module hsv_to_rgb_converter_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  hsvrgb_in_if.sink    in_pix,
  hsvrgb_out_if.source out_pix
);

  hsvrgb_pkg::hsva_t   in_data;
  hsvrgb_pkg::split_t  split_data;
  hsvrgb_pkg::frac_t   frac_data;
  hsvrgb_pkg::scale_t  scale_data;
  hsvrgb_pkg::rgba_t   rgba_data;
  logic                split_valid;
  logic                split_ready;
  logic                frac_valid;
  logic                frac_ready;
  logic                scale_valid;
  logic                scale_ready;

  // Pack input channel payload
  always_comb begin
    in_data.hue        = in_pix.hue;
    in_data.saturation = in_pix.saturation;
    in_data.brightness = in_pix.brightness;
    in_data.alpha      = in_pix.alpha_in;
  end

  hsvrgb_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .up_data  (in_data),
    .dn_valid (split_valid),
    .dn_ready (split_ready),
    .dn_data  (split_data)
  );

  hsvrgb_frac u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (split_valid),
    .up_ready (split_ready),
    .up_data  (split_data),
    .dn_valid (frac_valid),
    .dn_ready (frac_ready),
    .dn_data  (frac_data)
  );

  hsvrgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (frac_valid),
    .up_ready (frac_ready),
    .up_data  (frac_data),
    .dn_valid (scale_valid),
    .dn_ready (scale_ready),
    .dn_data  (scale_data)
  );

  hsvrgb_route u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (scale_valid),
    .up_ready (scale_ready),
    .up_data  (scale_data),
    .dn_valid (out_pix.valid),
    .dn_ready (out_pix.ready),
    .dn_data  (rgba_data)
  );

  // Unpack result payload
  assign out_pix.red       = rgba_data.red;
  assign out_pix.green     = rgba_data.green;
  assign out_pix.blue      = rgba_data.blue;
  assign out_pix.alpha_out = rgba_data.alpha;

endmodule

`default_nettype wire
